/* hw/rtl/pts_pkg.sv */
// Shared types and constants of the periodic task scheduler.
package pts_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int TIME_BITS_DEF = 32;
    localparam int CNT_W         = 32;
    localparam int MAX_OUT       = 8;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ENABLE  = 3'd1,
        OP_DISABLE = 3'd2,
        OP_RESCHED = 3'd3,
        OP_PERIOD  = 3'd4,
        OP_DELAY   = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  task_index;
        logic [31:0] setting_value;
        logic [31:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  fired_task;
        logic [31:0] tardiness_ms;
        logic [31:0] runs_done;
        logic        last_fired;
    } result_t;

endpackage

/* hw/rtl/pts_table.sv */
// Task table memory with per-entry valid bits; an unwritten entry reads as the reset value.
module pts_table #(
    parameter int                DEPTH       = 8,
    parameter int                DATA_W      = 8,
    parameter logic [DATA_W-1:0] RESET_VALUE = '0,
    parameter int                ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_q_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              valid_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            valid_q_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem_reg[rd_addr];
    end

    assign rd_data = valid_q_reg ? rd_q_reg : RESET_VALUE;

endmodule

/* hw/rtl/pts_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
module pts_divider #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  rem_nonzero
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,    busy_next;
    logic                  done_reg,    done_next;
    logic [STEP_W-1:0]     step_reg,    step_next;
    logic [DIVISOR_W-1:0]  rem_reg,     rem_next;
    logic [DIVIDEND_W-1:0] quo_reg,     quo_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        rem_sh       = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits         = rem_sh >= {1'b0, divisor_reg};
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = STEP_W'(DIVIDEND_W);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when the divisor fits
            rem_next  = fits ? DIVISOR_W'(rem_sh - {1'b0, divisor_reg})
                             : rem_sh[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = |rem_reg;

endmodule

/* hw/rtl/periodic_task_scheduler_top.sv */
// Periodic task scheduler: sequencer over the task table and the serial divider.
// busy stays high while an enable, disable, write period or write delay transfer reads and writes
// its row, while reschedule all walks every row, and not at all for an unknown op. A tick holds
// busy over one scan of all rows per firing plus a closing scan, and each firing waits on the
// divider; a tick that reaches MAX_OUT (eight) firings ends in a flush state, not a closing scan.
// Results are 1-cycle strobes that cannot be stalled. Reset clears control, marks rows unwritten.
module periodic_task_scheduler_top #(
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
    parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pts_pkg::cmd_t    cmd,
    output logic             result_valid,
    output pts_pkg::result_t result
);

    import pts_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int FC_W  = $clog2(MAX_OUT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    // One table row per task; due_time all ones means never.
    typedef struct packed {
        logic                 active;
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] delay;
        logic [TIME_BITS-1:0] prev_time;
        logic [TIME_BITS-1:0] due_time;
        logic [TIME_BITS-1:0] mean;
        logic [CNT_W-1:0]     count;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        active:    1'b0,
        period:    '0,
        delay:     '0,
        prev_time: '0,
        due_time:  '1,
        mean:      '0,
        count:     '0
    };

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_ISSUE    = 12'b0000_0000_0010,
        ST_MODIFY   = 12'b0000_0000_0100,
        ST_SCAN_RD  = 12'b0000_0000_1000,
        ST_SCAN_CMP = 12'b0000_0001_0000,
        ST_FETCH_RD = 12'b0000_0010_0000,
        ST_FETCH    = 12'b0000_0100_0000,
        ST_PREP     = 12'b0000_1000_0000,
        ST_DIVIDE   = 12'b0001_0000_0000,
        ST_UPDATE   = 12'b0010_0000_0000,
        ST_FINISH   = 12'b0100_0000_0000,
        ST_FLUSH    = 12'b1000_0000_0000
    } state_t;

    // Saturating time add: a carry out of the time width means never.
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    state_t               state_reg,     state_next;
    logic [2:0]           op_reg,        op_next;
    logic [TIME_BITS-1:0] now_reg,       now_next;
    logic [TIME_BITS-1:0] val_reg,       val_next;
    logic [IDX_W-1:0]     addr_reg,      addr_next;
    logic [IDX_W-1:0]     best_idx_reg,  best_idx_next;
    logic [TIME_BITS-1:0] best_next_reg, best_next_next;
    logic                 found_reg,     found_next;
    logic [FC_W-1:0]      fire_cnt_reg,  fire_cnt_next;
    entry_t               ent_reg,       ent_next;
    logic [TIME_BITS-1:0] interval_reg,  interval_next;
    logic                 ge_reg,        ge_next;
    logic                 pend_vld_reg,  pend_vld_next;
    result_t              pend_reg,      pend_next;
    logic                 res_vld_reg,   res_vld_next;
    result_t              res_reg,       res_next;

    // table and divider hookup
    logic [$bits(entry_t)-1:0] tbl_rd_data;
    entry_t                    rd_ent;
    logic                      tbl_wr_en;
    entry_t                    tbl_wr_data;
    logic                      div_start;
    logic [TIME_BITS-1:0]      div_dividend;
    logic                      div_done;
    logic [TIME_BITS-1:0]      div_quotient;
    logic                      div_rem_nz;

    // scratch for the sequencer
    logic                 cand;
    logic [TIME_BITS-1:0] when_t;
    logic [TIME_BITS-1:0] tard;
    logic [FC_W-1:0]      fire_cnt_inc;

    assign rd_ent = entry_t'(tbl_rd_data);

    pts_table #(
        .DEPTH       (NUM_TASKS),
        .DATA_W      ($bits(entry_t)),
        .RESET_VALUE (ENTRY_RESET),
        .ADDR_W      (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (addr_reg),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (addr_reg),
        .wr_data (tbl_wr_data)
    );

    pts_divider #(
        .DIVIDEND_W (TIME_BITS),
        .DIVISOR_W  (CNT_W)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (div_dividend),
        .divisor     (ent_reg.count),
        .done        (div_done),
        .quotient    (div_quotient),
        .rem_nonzero (div_rem_nz)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        best_idx_next  = best_idx_reg;
        best_next_next = best_next_reg;
        found_next     = found_reg;
        fire_cnt_next  = fire_cnt_reg;
        ent_next       = ent_reg;
        interval_next  = interval_reg;
        ge_next        = ge_reg;
        pend_vld_next  = pend_vld_reg;
        pend_next      = pend_reg;
        res_vld_next   = 1'b0;
        res_next       = res_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_data    = ent_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        cand           = 1'b0;
        when_t         = sat_add(now_reg, rd_ent.delay);
        tard           = (ent_reg.mean > ent_reg.period) ? ent_reg.mean - ent_reg.period : '0;
        fire_cnt_inc   = fire_cnt_reg + 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.op;
                    now_next = TIME_BITS'(cmd.now_ms);
                    val_next = TIME_BITS'(cmd.setting_value);
                    unique case (cmd.op)
                        OP_TICK:
                        begin
                            addr_next     = '0;
                            found_next    = 1'b0;
                            fire_cnt_next = '0;
                            pend_vld_next = 1'b0;
                            state_next    = ST_SCAN_RD;
                        end
                        OP_RESCHED:
                        begin
                            addr_next  = '0;
                            state_next = ST_ISSUE;
                        end
                        OP_ENABLE, OP_DISABLE, OP_PERIOD, OP_DELAY:
                        begin
                            // drop indexes beyond the table
                            if ({29'd0, cmd.task_index} < 32'(NUM_TASKS))
                            begin
                                addr_next  = IDX_W'(cmd.task_index);
                                state_next = ST_ISSUE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ISSUE:
            begin
                state_next = ST_MODIFY;
            end

            ST_MODIFY:
            begin
                // read-modify-write of the addressed row
                tbl_wr_data = rd_ent;
                unique case (op_reg)
                    OP_ENABLE:
                    begin
                        tbl_wr_data.active    = 1'b1;
                        tbl_wr_data.prev_time = when_t;
                        tbl_wr_data.due_time  = when_t;
                    end
                    OP_DISABLE:
                    begin
                        tbl_wr_data.active = 1'b0;
                    end
                    OP_RESCHED:
                    begin
                        tbl_wr_data.prev_time = when_t;
                        tbl_wr_data.due_time  = when_t;
                    end
                    OP_PERIOD:
                    begin
                        tbl_wr_data.period = val_reg;
                    end
                    OP_DELAY:
                    begin
                        tbl_wr_data.delay = val_reg;
                    end
                    default:
                    begin
                    end
                endcase
                tbl_wr_en = 1'b1;
                if (op_reg == OP_RESCHED && addr_reg != LAST_IDX)
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                // strict earlier-than keeps the lower index on ties
                cand = rd_ent.active && (now_reg > rd_ent.due_time) &&
                       (!found_reg || (rd_ent.due_time < best_next_reg));
                if (cand)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = addr_reg;
                    best_next_next = rd_ent.due_time;
                end
                if (addr_reg != LAST_IDX)
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else if (found_reg || cand)
                begin
                    // another firing follows, so the held result is not the last
                    addr_next = cand ? addr_reg : best_idx_reg;
                    if (pend_vld_reg)
                    begin
                        res_vld_next          = 1'b1;
                        res_next              = pend_reg;
                        res_next.last_fired   = 1'b0;
                        pend_vld_next         = 1'b0;
                    end
                    state_next = ST_FETCH_RD;
                end
                else
                begin
                    if (pend_vld_reg)
                    begin
                        res_vld_next        = 1'b1;
                        res_next            = pend_reg;
                        res_next.last_fired = 1'b1;
                        pend_vld_next       = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FETCH_RD:
            begin
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                ent_next = rd_ent;
                if (rd_ent.count != '1)
                begin
                    ent_next.count = rd_ent.count + 1'b1;
                end
                interval_next = (now_reg >= rd_ent.prev_time) ? now_reg - rd_ent.prev_time
                                                               : '0;
                state_next    = ST_PREP;
            end

            ST_PREP:
            begin
                ge_next      = interval_reg >= ent_reg.mean;
                div_dividend = (interval_reg >= ent_reg.mean) ? interval_reg - ent_reg.mean
                                                              : ent_reg.mean - interval_reg;
                div_start    = 1'b1;
                state_next   = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // mean moves up by the floor, down by the ceiling of the step
                ent_next.mean = ge_reg ? ent_reg.mean + div_quotient
                                       : ent_reg.mean - (div_quotient +
                                                         TIME_BITS'(div_rem_nz));
                ent_next.prev_time = now_reg;
                ent_next.due_time  = (ent_reg.period != '0) ? sat_add(now_reg, ent_reg.period)
                                                            : '1;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                addr_next               = best_idx_reg;
                tbl_wr_en               = 1'b1;
                pend_vld_next           = 1'b1;
                pend_next.fired_task    = 3'(best_idx_reg);
                pend_next.tardiness_ms  = 32'(tard);
                pend_next.runs_done     = ent_reg.count;
                pend_next.last_fired    = 1'b0;
                fire_cnt_next           = fire_cnt_inc;
                if (fire_cnt_inc == FC_W'(MAX_OUT))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_FLUSH:
            begin
                res_vld_next        = 1'b1;
                res_next            = pend_reg;
                res_next.last_fired = 1'b1;
                pend_vld_next       = 1'b0;
                state_next          = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // restart the scan from the first row once the firing row is written back
        if (state_reg == ST_FINISH)
        begin
            addr_next = '0;
        end
    end

    // write address is addr_reg; hold it on the best row while it is written back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            found_reg    <= 1'b0;
            fire_cnt_reg <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            addr_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            found_reg    <= found_next;
            fire_cnt_reg <= fire_cnt_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
            addr_reg     <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        val_reg       <= val_next;
        best_idx_reg  <= best_idx_next;
        best_next_reg <= best_next_next;
        ent_reg       <= ent_next;
        interval_reg  <= interval_next;
        ge_reg        <= ge_next;
        pend_reg      <= pend_next;
        res_reg       <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule
